[hdl/circular_queue_with_dedup_top_defines.svh]
// assertion macros for the circular queue with duplicate removal
`ifndef CIRCULAR_QUEUE_WITH_DEDUP_TOP_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_DEDUP_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CQD_ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CQD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hdl/cqd_pkg.sv]
// shared types, constants and helper functions for the circular queue with dedup
package cqd_pkg;

    localparam int DEPTH       = 8;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int VAL_W       = 32;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = 3;
    localparam int CNT_W       = IDX_W + OCC_W;
    localparam int OUT_TDATA_W = ((VAL_W + OCC_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - OCC_W;

    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEDUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DD_LOOP,
        S_DD_V,
        S_DD_K,
        S_DD_CMP,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RSEL_HEAD,
        RSEL_RD,
        RSEL_K
    } rsel_t;

    typedef struct packed {
        logic              load_req;
        logic              enq_commit;
        logic              deq_commit;
        logic              dd_init;
        logic              dd_latch_v;
        logic              dd_keep;
        logic              dd_skip;
        logic              dd_knext;
        logic              dd_finish;
        logic              out_load;
        logic              out_data_en;
        logic [STAT_W-1:0] out_status;
        rsel_t             rsel;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             rd_at_tail;
        logic             k_at_wr;
        logic             match;
        logic             out_free;
    } sts_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input idx_t head, input idx_t tail);
        logic [CNT_W-1:0] cnt;
        cnt = CNT_W'(tail) + ((tail < head) ? CNT_W'(DEPTH) : CNT_W'(0)) - CNT_W'(head);
        return cnt[OCC_W-1:0];
    endfunction

endpackage

[hdl/cqd_ctrl.sv]
// controller state machine sequencing enqueue, dequeue and duplicate removal
module cqd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cqd_pkg::sts_t sts,
    output cqd_pkg::cmd_t cmd
);

    cqd_pkg::state_t state_reg;
    cqd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = cqd_pkg::RSEL_HEAD;
        cmd.out_status = cqd_pkg::STAT_DONE;
        s_tready   = 1'b0;
        case (state_reg)
            cqd_pkg::S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = cqd_pkg::S_EXEC;
                end
            end
            cqd_pkg::S_EXEC:
            begin
                case (sts.req)
                    cqd_pkg::REQ_ENQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = sts.full ? cqd_pkg::STAT_FULL
                                                      : cqd_pkg::STAT_DONE;
                            cmd.enq_commit = !sts.full;
                            state_next     = cqd_pkg::S_IDLE;
                        end
                    end
                    cqd_pkg::REQ_DEQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load    = 1'b1;
                            cmd.out_status  = sts.empty ? cqd_pkg::STAT_EMPTY
                                                        : cqd_pkg::STAT_DONE;
                            cmd.out_data_en = !sts.empty;
                            cmd.deq_commit  = !sts.empty;
                            state_next      = cqd_pkg::S_IDLE;
                        end
                    end
                    cqd_pkg::REQ_DEDUP:
                    begin
                        cmd.dd_init = 1'b1;
                        state_next  = cqd_pkg::S_DD_LOOP;
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = cqd_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            cqd_pkg::S_DD_LOOP:
            begin
                if (sts.rd_at_tail)
                begin
                    cmd.dd_finish = 1'b1;
                    state_next    = cqd_pkg::S_RESP;
                end
                else
                begin
                    cmd.rsel   = cqd_pkg::RSEL_RD;
                    state_next = cqd_pkg::S_DD_V;
                end
            end
            cqd_pkg::S_DD_V:
            begin
                cmd.dd_latch_v = 1'b1;
                state_next     = cqd_pkg::S_DD_K;
            end
            cqd_pkg::S_DD_K:
            begin
                if (sts.k_at_wr)
                begin
                    cmd.dd_keep = 1'b1;
                    state_next  = cqd_pkg::S_DD_LOOP;
                end
                else
                begin
                    cmd.rsel   = cqd_pkg::RSEL_K;
                    state_next = cqd_pkg::S_DD_CMP;
                end
            end
            cqd_pkg::S_DD_CMP:
            begin
                if (sts.match)
                begin
                    cmd.dd_skip = 1'b1;
                    state_next  = cqd_pkg::S_DD_LOOP;
                end
                else
                begin
                    cmd.dd_knext = 1'b1;
                    state_next   = cqd_pkg::S_DD_K;
                end
            end
            cqd_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cqd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cqd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/cqd_dp.sv]
// datapath with entry store, ring indices, dedup walk registers and result register
module cqd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cqd_pkg::VAL_W-1:0]         s_tdata,
    input  logic [cqd_pkg::REQ_W-1:0]         s_tuser,
    input  cqd_pkg::cmd_t                     cmd,
    output cqd_pkg::sts_t                     sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cqd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [cqd_pkg::STAT_W-1:0]        m_tuser
);

    logic [cqd_pkg::VAL_W-1:0] mem [cqd_pkg::DEPTH];

    cqd_pkg::idx_t head_reg;
    cqd_pkg::idx_t head_next;
    cqd_pkg::idx_t tail_reg;
    cqd_pkg::idx_t tail_next;
    cqd_pkg::idx_t rd_reg;
    cqd_pkg::idx_t rd_next;
    cqd_pkg::idx_t wr_reg;
    cqd_pkg::idx_t wr_next;
    cqd_pkg::idx_t k_reg;
    cqd_pkg::idx_t k_next;
    cqd_pkg::idx_t raddr;
    cqd_pkg::idx_t waddr;

    logic                        wen;
    logic [cqd_pkg::VAL_W-1:0]   wdata;
    logic [cqd_pkg::VAL_W-1:0]   rdata_reg;
    logic [cqd_pkg::VAL_W-1:0]   v_reg;
    logic [cqd_pkg::VAL_W-1:0]   val_reg;
    logic [cqd_pkg::REQ_W-1:0]   req_reg;
    logic                        ovalid_reg;
    logic [cqd_pkg::STAT_W-1:0]  ostatus_reg;
    logic [cqd_pkg::VAL_W-1:0]   odata_reg;
    logic [cqd_pkg::OCC_W-1:0]   oocc_reg;

    always_comb
    begin
        head_next = cmd.deq_commit ? cqd_pkg::idx_inc(head_reg) : head_reg;
        tail_next = tail_reg;
        if (cmd.enq_commit)
        begin
            tail_next = cqd_pkg::idx_inc(tail_reg);
        end
        else if (cmd.dd_finish)
        begin
            tail_next = wr_reg;
        end

        rd_next = rd_reg;
        wr_next = wr_reg;
        k_next  = k_reg;
        if (cmd.dd_init)
        begin
            rd_next = head_reg;
            wr_next = head_reg;
        end
        if (cmd.dd_keep)
        begin
            wr_next = cqd_pkg::idx_inc(wr_reg);
            rd_next = cqd_pkg::idx_inc(rd_reg);
        end
        if (cmd.dd_skip)
        begin
            rd_next = cqd_pkg::idx_inc(rd_reg);
        end
        if (cmd.dd_latch_v)
        begin
            k_next = head_reg;
        end
        if (cmd.dd_knext)
        begin
            k_next = cqd_pkg::idx_inc(k_reg);
        end

        case (cmd.rsel)
            cqd_pkg::RSEL_RD: raddr = rd_reg;
            cqd_pkg::RSEL_K:  raddr = k_reg;
            default:          raddr = head_reg;
        endcase

        wen   = cmd.enq_commit || cmd.dd_keep;
        waddr = cmd.dd_keep ? wr_reg : tail_reg;
        wdata = cmd.dd_keep ? v_reg : val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            rd_reg     <= '0;
            wr_reg     <= '0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            k_reg    <= k_next;
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= s_tuser;
            val_reg <= s_tdata;
        end
        if (cmd.dd_latch_v)
        begin
            v_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            ostatus_reg <= cmd.out_status;
            odata_reg   <= cmd.out_data_en ? rdata_reg : '0;
            oocc_reg    <= cqd_pkg::occ_of(head_next, tail_next);
        end
    end

    always_comb
    begin
        sts.req        = req_reg;
        sts.full       = (cqd_pkg::idx_inc(tail_reg) == head_reg);
        sts.empty      = (head_reg == tail_reg);
        sts.rd_at_tail = (rd_reg == tail_reg);
        sts.k_at_wr    = (k_reg == wr_reg);
        sts.match      = (rdata_reg == v_reg);
        sts.out_free   = !ovalid_reg || m_tready;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{cqd_pkg::OUT_PAD_W{1'b0}}, oocc_reg, odata_reg};
    assign m_tuser  = ostatus_reg;

endmodule

[hdl/circular_queue_with_dedup_top.sv]
// top level of the circular queue with duplicate removal
// A ring of DEPTH 32-bit entries holding at most DEPTH-1 values. Each input transaction
// carries a request in s_tuser (enqueue, dequeue, remove duplicates) and a value in
// s_tdata; each gives exactly one output transaction with status in m_tuser and the
// dequeued value and the new occupancy in m_tdata. Enqueue, dequeue and unused codes
// are executed after the accept and load their result into the output register once
// it is free, the dequeued value coming from the registered read of the entry store.
// Remove duplicates walks the store with one read port: for n entries held, the
// number of compares against kept entries is at most n(n-1)/2. A new transaction
// is taken while a result still waits on m_tready.
`include "circular_queue_with_dedup_top_defines.svh"

module circular_queue_with_dedup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cqd_pkg::VAL_W-1:0]         s_tdata,  // value_in
    input  logic [cqd_pkg::REQ_W-1:0]         s_tuser,  // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cqd_pkg::OUT_TDATA_W-1:0]   m_tdata,  // value_out, occupancy, zero pad
    output logic [cqd_pkg::STAT_W-1:0]        m_tuser   // status
);

    cqd_pkg::cmd_t cmd;
    cqd_pkg::sts_t sts;

    cqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cqd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CQD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "second transaction accepted while one is in flight")

    `CQD_ASSERT_SAME(a_out_slot_free, clk, rst_n, cmd.out_load, !m_tvalid || m_tready,
        "result loaded over one still waiting")

    `CQD_ASSERT_SAME(a_no_enq_when_full, clk, rst_n, cmd.enq_commit, !sts.full,
        "enqueue written into a full ring")

    `CQD_ASSERT_SAME(a_no_deq_when_empty, clk, rst_n, cmd.deq_commit, !sts.empty,
        "dequeue taken from an empty ring")

endmodule

[sim/cqd_checker.sv]
// checker for the circular queue with dedup: ring buffer prediction and result comparison
`timescale 1ns / 100ps

module cqd_checker
    import cqd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [VAL_W-1:0]       s_tdata,
    input  logic [REQ_W-1:0]       s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]      m_tuser,
    output int                     mismatches,
    output int                     pending
);

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [OCC_W-1:0]  occ;
    } queue_result_t;

    logic [VAL_W-1:0] ring [DEPTH];
    int unsigned      front;
    int unsigned      back;
    queue_result_t    queued_results [$];

    function automatic int unsigned wrap_inc(input int unsigned i);
        return (i + 1) % DEPTH;
    endfunction

    // ring update and result for one request
    function automatic queue_result_t serve_request(input logic [REQ_W-1:0] req,
                                                    input logic [VAL_W-1:0] val);
        queue_result_t    res;
        int unsigned      rd;
        int unsigned      wr;
        int unsigned      k;
        logic [VAL_W-1:0] v;
        bit               seen;
        res.status = STAT_DONE;
        res.value  = '0;
        if (req == REQ_ENQ)
        begin
            if (wrap_inc(back) == front)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                ring[back] = val;
                back = wrap_inc(back);
            end
        end
        else if (req == REQ_DEQ)
        begin
            if (front == back)
            begin
                res.status = STAT_EMPTY;
            end
            else
            begin
                res.value = ring[front];
                front = wrap_inc(front);
            end
        end
        else if (req == REQ_DEDUP)
        begin
            rd = front;
            wr = front;
            while (rd != back)
            begin
                v = ring[rd];
                seen = 1'b0;
                k = front;
                while (k != wr && !seen)
                begin
                    if (ring[k] == v)
                        seen = 1'b1;
                    else
                        k = wrap_inc(k);
                end
                if (!seen)
                begin
                    ring[wr] = v;
                    wr = wrap_inc(wr);
                end
                rd = wrap_inc(rd);
            end
            back = wr;
        end
        res.occ = OCC_W'((back + DEPTH - front) % DEPTH);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            front = 0;
            back = 0;
            queued_results.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (queued_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction expected none actual %h/%h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = queued_results.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(m_tuser));
                    check_field("value_out", want.value, m_tdata[VAL_W-1:0]);
                    check_field("occupancy", VAL_W'(want.occ), VAL_W'(m_tdata[VAL_W +: OCC_W]));
                    check_field("pad", '0, VAL_W'(m_tdata[OUT_TDATA_W-1:VAL_W+OCC_W]));
                end
            end
            if (s_tvalid && s_tready)
                queued_results.push_back(serve_request(s_tuser, s_tdata));
            pending = queued_results.size();
        end
    end

endmodule

[sim/tb_top.sv]
// testbench top for the circular queue with dedup: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_top;
    import cqd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VAL_W-1:0]       s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;
    int holds_asked = 0;
    int holds_taken = 0;
    logic [VAL_W-1:0] dup_pool [4];

    circular_queue_with_dedup_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cqd_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("circular_queue_with_dedup_top: mismatch");
            $finish;
        end
    end

    // receiver: changing stall modes, plus long hold-offs on request
    initial
    begin
        int mode;
        int len;
        m_tready <= 1'b0;
        forever
        begin
            if (holds_taken != holds_asked)
            begin
                holds_taken++;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(10, 60);
                repeat (len)
                begin
                    @(negedge clk);
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata <= $urandom;
                s_tuser <= REQ_W'($urandom_range(0, 3));
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= val;
        s_tuser <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mostly a small pool so dedup has something to remove
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return dup_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return REQ_ENQ;
        else if (r < 92)
            return REQ_DEQ;
        else if (r < 98)
            return REQ_DEDUP;
        else
            return REQ_UNUSED;
    endfunction

    initial
    begin
        int enq_pct;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= REQ_ENQ;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue cases
        send_item(REQ_DEQ, 32'h0000_0000);
        send_item(REQ_DEDUP, 32'h0000_0000);
        send_item(REQ_UNUSED, 32'hffff_ffff);
        // fill with extremes and repeats
        send_item(REQ_ENQ, 32'h8000_0000);
        send_item(REQ_ENQ, 32'h7fff_ffff);
        send_item(REQ_ENQ, 32'h0000_0000);
        send_item(REQ_ENQ, 32'hffff_ffff);
        send_item(REQ_ENQ, 32'h7fff_ffff);
        send_item(REQ_ENQ, 32'h8000_0000);
        send_item(REQ_ENQ, 32'h0000_0000);
        // full queue cases
        send_item(REQ_ENQ, 32'h0000_0005);
        send_item(REQ_UNUSED, 32'h5555_aaaa);
        send_item(REQ_DEDUP, 32'haaaa_5555);
        send_item(REQ_DEQ, 32'h0000_0000);
        send_item(REQ_DEQ, 32'h0000_0000);
        // duplicates added after the head has moved off index zero
        send_item(REQ_ENQ, 32'h1234_5678);
        send_item(REQ_ENQ, 32'h1234_5678);
        send_item(REQ_ENQ, 32'hffff_ffff);
        send_item(REQ_DEDUP, 32'h0000_0000);
        send_item(REQ_DEQ, 32'h0000_0000);
        send_item(REQ_DEQ, 32'h0000_0000);
        send_item(REQ_DEQ, 32'h0000_0000);
        send_item(REQ_DEQ, 32'h0000_0000);
        wait_drained();

        enq_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 75;
                endcase
                foreach (dup_pool[j])
                    dup_pool[j] = $urandom;
            end
            if (i == 300 || i == 650)
                holds_asked++;
            if (i % 150 == 75)
                wait_drained();
            send_item(pick_request(enq_pct), pick_value());
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("circular_queue_with_dedup_top: match");
        else
            $display("circular_queue_with_dedup_top: mismatch");
        $finish;
    end

endmodule
